[rtl/core/hermite_spline_evaluator_core_assert.svh]
// assertion macros for the hermite spline evaluator core
`ifndef HERMITE_SPLINE_EVALUATOR_CORE_ASSERT_SVH
`define HERMITE_SPLINE_EVALUATOR_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// checked while out of reset
`define HSE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("hse assertion failed");
// checked on every edge, reset included
`define HSE_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("hse assertion failed");
`else
`define HSE_ASSERT(lbl, prop)
`define HSE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[rtl/core/hse_pkg.sv]
// types and constants shared by the hermite spline evaluator core
`timescale 1ns / 1ps
package hse_pkg;
    localparam int unsigned VAL_W    = 32;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned CNT_W    = 7;
    localparam int unsigned HORNER_W = 40;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_POS  = 2'd1,
        OP_VEL  = 2'd2,
        OP_ACC  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        KIND_LOAD  = 2'd0,
        KIND_FEW   = 2'd1,
        KIND_QUERY = 2'd2
    } t_kind;

    typedef struct packed {
        logic signed [VAL_W-1:0] px;
        logic signed [VAL_W-1:0] py;
        logic signed [VAL_W-1:0] pz;
        logic signed [VAL_W-1:0] inx;
        logic signed [VAL_W-1:0] iny;
        logic signed [VAL_W-1:0] inz;
        logic signed [VAL_W-1:0] outx;
        logic signed [VAL_W-1:0] outy;
        logic signed [VAL_W-1:0] outz;
    } t_row;

    typedef struct packed {
        t_kind                   kind;
        t_opcode                 op;
        logic [IDX_W-1:0]        idx;
        logic signed [VAL_W-1:0] tval;
        t_row                    row;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_head;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_RD_FIRST,
        BK_RD_LAST,
        BK_SEARCH,
        BK_DIV_SETUP,
        BK_DIV,
        BK_ROW0,
        BK_ROW1,
        BK_ROW2,
        BK_COEF,
        BK_MUL,
        BK_ADD,
        BK_CLAMP,
        BK_OUT
    } t_bk_state;
endpackage

[rtl/core/hse_ram.sv]
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/hse_front.sv]
// front end: key count register, item classification and two-entry queue
`timescale 1ns / 1ps
module hse_front import hse_pkg::*; #(
    parameter int MAX_KEYS = 64,
    parameter int CW       = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    output logic                    o_busy,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic [1:0]              i_opcode,
    input  logic [IDX_W-1:0]        i_key_index,
    input  logic signed [VAL_W-1:0] i_time_value,
    input  t_row                    i_row,
    input  logic                    i_pop,
    output t_q_head                 o_head,
    output logic [CW-1:0]           o_key_num
);
    logic [CNT_W-1:0] r_key_count;
    t_item            r_q [2];
    logic             r_wr_ptr;
    logic             r_rd_ptr;
    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    t_item            c_item;
    logic             c_push;
    logic             c_keep;

    // key count beyond the table acts as a full table
    assign o_key_num = (CW'(r_key_count) > CW'(MAX_KEYS)) ? CW'(MAX_KEYS) : CW'(r_key_count);

    always_comb begin
        c_item.op   = t_opcode'(i_opcode);
        c_item.idx  = i_key_index;
        c_item.tval = i_time_value;
        c_item.row  = i_row;
        if (c_item.op == OP_LOAD) begin
            c_item.kind = KIND_LOAD;
        end else if (o_key_num < CW'(2)) begin
            c_item.kind = KIND_FEW;
        end else begin
            c_item.kind = KIND_QUERY;
        end
        // loads beyond the table are swallowed here
        c_keep = !(c_item.op == OP_LOAD && 32'(i_key_index) >= 32'(MAX_KEYS));
        c_push = i_start && !o_busy && c_keep;
        n_cnt  = r_cnt + {1'b0, c_push} - {1'b0, i_pop};
    end

    assign o_busy       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_wr_ptr    <= 1'b0;
            r_rd_ptr    <= 1'b0;
            r_cnt       <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_key_count <= i_cfg_wdata;
            end
            if (c_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_push) begin
            r_q[r_wr_ptr] <= c_item;
        end
    end
endmodule

[rtl/core/hse_back.sv]
// back end: key writes, segment search, divider for u and horner evaluation
`timescale 1ns / 1ps
`include "hermite_spline_evaluator_core_assert.svh"
module hse_back import hse_pkg::*; #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16,
    parameter int CW        = 7
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_q_head                     i_head,
    input  logic [CW-1:0]               i_key_num,
    output logic                        o_pop,
    output logic                        o_we,
    output logic [$clog2(MAX_KEYS)-1:0] o_waddr,
    output logic [$clog2(MAX_KEYS)-1:0] o_tm_raddr,
    input  logic signed [VAL_W-1:0]     i_tm_rdata,
    output logic [$clog2(MAX_KEYS)-1:0] o_row_raddr,
    input  t_row                        i_row_rdata,
    output logic                        o_result_strobe,
    output logic signed [VAL_W-1:0]     o_result_x,
    output logic signed [VAL_W-1:0]     o_result_y,
    output logic signed [VAL_W-1:0]     o_result_z,
    output logic                        o_too_few_keys
);
    localparam int AW     = $clog2(MAX_KEYS);
    localparam int IW     = (AW > IDX_W) ? AW : IDX_W;
    localparam int UW     = FRAC_BITS + 1;
    localparam int FC_W   = $clog2(FRAC_BITS + 1);
    localparam int PROD_W = HORNER_W + UW + 1;
    localparam int DW     = VAL_W + 1;
    localparam logic [CW-1:0] ONE_C = CW'(1);

    function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [HORNER_W-1:0] v);
        logic [HORNER_W-VAL_W:0] top;
        logic signed [VAL_W-1:0] res;
        top = v[HORNER_W-1:VAL_W-1];
        if (&top || ~|top) begin
            res = v[VAL_W-1:0];
        end else if (v[HORNER_W-1]) begin
            res = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return res;
    endfunction

    t_bk_state r_state, n_state;
    t_opcode   r_op, n_op;
    logic signed [VAL_W-1:0] r_t, n_t, r_first, n_first, r_last, n_last;
    logic signed [VAL_W-1:0] r_t0, n_t0, r_t1, n_t1;
    logic [CW-1:0]    r_idx, n_idx;
    logic [DW-1:0]    r_rem, n_rem;
    logic [VAL_W-1:0] r_den, n_den;
    logic [UW-1:0]    r_u, n_u;
    logic [FC_W-1:0]  r_div_cnt, n_div_cnt;
    t_row             r_row0, n_row0, r_row1, n_row1;
    logic [1:0]       r_comp, n_comp, r_step, n_step;
    logic signed [HORNER_W-1:0] r_b, n_b, r_h, n_h;
    logic signed [PROD_W-1:0]   r_prod, n_prod;
    logic signed [VAL_W-1:0]    r_res [3];
    logic signed [VAL_W-1:0]    n_res [3];
    logic r_few, n_few;

    logic signed [VAL_W-1:0]    c_p0, c_p1, c_t0, c_t1;
    logic signed [HORNER_W-1:0] c_a, c_bv, c_add;
    logic signed [PROD_W-1:0]   c_shift;
    logic signed [DW-1:0]       c_num, c_den;
    logic [DW:0]                c_rem2;
    logic                       c_hit, c_last_step, c_lo;
    logic [CW-1:0]              c_nidx;
    logic [IW-1:0]              c_widx;

    assign c_widx  = IW'(i_head.item.idx);
    assign o_waddr = c_widx[AW-1:0];

    always_comb begin
        // component select for the horner steps
        case (r_comp)
            2'd0: begin
                c_p0 = r_row0.px; c_p1 = r_row1.px; c_t0 = r_row0.inx; c_t1 = r_row0.outx;
            end
            2'd1: begin
                c_p0 = r_row0.py; c_p1 = r_row1.py; c_t0 = r_row0.iny; c_t1 = r_row0.outy;
            end
            default: begin
                c_p0 = r_row0.pz; c_p1 = r_row1.pz; c_t0 = r_row0.inz; c_t1 = r_row0.outz;
            end
        endcase
        c_a  = 2 * HORNER_W'(c_p0) - 2 * HORNER_W'(c_p1) + HORNER_W'(c_t0) + HORNER_W'(c_t1);
        c_bv = 3 * HORNER_W'(c_p1) - 3 * HORNER_W'(c_p0) - 2 * HORNER_W'(c_t0)
             - HORNER_W'(c_t1);
        case (r_op)
            OP_POS: begin
                c_last_step = (r_step == 2'd2);
                case (r_step)
                    2'd0:    c_add = r_b;
                    2'd1:    c_add = HORNER_W'(c_t0);
                    default: c_add = HORNER_W'(c_p0);
                endcase
            end
            OP_VEL: begin
                c_last_step = (r_step == 2'd1);
                c_add       = (r_step == 2'd0) ? 2 * r_b : HORNER_W'(c_t0);
            end
            default: begin
                c_last_step = 1'b1;
                c_add       = 2 * r_b;
            end
        endcase
        c_shift = r_prod >>> FRAC_BITS;
        c_num   = DW'(r_t) - DW'(r_t0);
        c_den   = DW'(r_t1) - DW'(r_t0);
        c_rem2  = {r_rem, 1'b0};
        c_hit   = (r_op == OP_ACC) ? (r_t <= i_tm_rdata) : (r_t < i_tm_rdata);
        c_nidx  = r_idx + ONE_C;
        c_lo    = (r_t <= r_first);
    end

    always_comb begin
        n_state = r_state; n_op = r_op; n_t = r_t; n_first = r_first; n_last = r_last;
        n_t0 = r_t0; n_t1 = r_t1; n_idx = r_idx; n_rem = r_rem; n_den = r_den;
        n_u = r_u; n_div_cnt = r_div_cnt; n_row0 = r_row0; n_row1 = r_row1;
        n_comp = r_comp; n_step = r_step; n_b = r_b; n_h = r_h; n_prod = r_prod;
        n_res = r_res; n_few = r_few;
        o_pop = 1'b0; o_we = 1'b0;
        o_tm_raddr = '0; o_row_raddr = '0;
        case (r_state)
            BK_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    n_op  = i_head.item.op;
                    n_t   = i_head.item.tval;
                    n_few = 1'b0;
                    case (i_head.item.kind)
                        KIND_LOAD: o_we = 1'b1;
                        KIND_FEW: begin
                            n_few   = 1'b1;
                            n_res   = '{default: '0};
                            n_state = BK_OUT;
                        end
                        default: n_state = BK_RD_FIRST;
                    endcase
                end
            end
            BK_RD_FIRST: begin
                n_first    = i_tm_rdata;
                o_tm_raddr = AW'(i_key_num - ONE_C);
                n_state    = BK_RD_LAST;
            end
            BK_RD_LAST: begin
                n_last = i_tm_rdata;
                n_t0   = r_first;
                n_idx  = '0;
                if (r_op != OP_ACC && (c_lo || r_t >= i_tm_rdata)) begin
                    if (c_lo) begin
                        o_row_raddr = '0;
                    end else if (r_op == OP_POS) begin
                        o_row_raddr = AW'(i_key_num - ONE_C);
                    end else begin
                        o_row_raddr = AW'(i_key_num - ONE_C - ONE_C);
                    end
                    n_first = {VAL_W{c_lo}};
                    n_state = BK_CLAMP;
                end else begin
                    if (r_op == OP_ACC) begin
                        if (c_lo) begin
                            n_t = r_first;
                        end else if (r_t > i_tm_rdata) begin
                            n_t = i_tm_rdata;
                        end
                    end
                    if (i_key_num == CW'(2)) begin
                        n_t1    = i_tm_rdata;
                        n_state = BK_DIV_SETUP;
                    end else begin
                        o_tm_raddr = AW'(ONE_C);
                        n_state    = BK_SEARCH;
                    end
                end
            end
            BK_SEARCH: begin
                // one key time a cycle until the segment end passes t or the last segment is reached
                if (c_hit) begin
                    n_t1    = i_tm_rdata;
                    n_state = BK_DIV_SETUP;
                end else begin
                    n_t0  = i_tm_rdata;
                    n_idx = c_nidx;
                    if (c_nidx == i_key_num - ONE_C - ONE_C) begin
                        n_t1    = r_last;
                        n_state = BK_DIV_SETUP;
                    end else begin
                        o_tm_raddr = AW'(c_nidx + ONE_C);
                    end
                end
            end
            BK_DIV_SETUP: begin
                n_u       = '0;
                n_rem     = c_num;
                n_den     = c_den[VAL_W-1:0];
                n_div_cnt = FC_W'(FRAC_BITS);
                if (c_num[DW-1] || c_num == '0 || c_den[DW-1] || c_den == '0) begin
                    n_state = BK_ROW0;
                end else if (c_num >= c_den) begin
                    n_u     = UW'(1) << FRAC_BITS;
                    n_state = BK_ROW0;
                end else begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                // restoring division, one quotient bit a cycle
                if (c_rem2 >= (DW+1)'(r_den)) begin
                    n_rem = DW'(c_rem2 - (DW+1)'(r_den));
                    n_u   = {r_u[UW-2:0], 1'b1};
                end else begin
                    n_rem = c_rem2[DW-1:0];
                    n_u   = {r_u[UW-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt - FC_W'(1);
                if (r_div_cnt == FC_W'(1)) begin
                    n_state = BK_ROW0;
                end
            end
            BK_ROW0: begin
                o_row_raddr = AW'(r_idx);
                n_state     = BK_ROW1;
            end
            BK_ROW1: begin
                n_row0      = i_row_rdata;
                o_row_raddr = AW'(c_nidx);
                n_state     = BK_ROW2;
            end
            BK_ROW2: begin
                n_row1  = i_row_rdata;
                n_comp  = 2'd0;
                n_state = BK_COEF;
            end
            BK_COEF: begin
                n_b    = c_bv;
                n_step = 2'd0;
                case (r_op)
                    OP_POS:  n_h = c_a;
                    OP_VEL:  n_h = 3 * c_a;
                    default: n_h = 6 * c_a;
                endcase
                n_state = BK_MUL;
            end
            BK_MUL: begin
                n_prod  = PROD_W'(r_h) * PROD_W'($signed({1'b0, r_u}));
                n_state = BK_ADD;
            end
            BK_ADD: begin
                n_h = c_add + c_shift[HORNER_W-1:0];
                if (c_last_step) begin
                    n_res[r_comp] = sat_val(n_h);
                    if (r_comp == 2'd2) begin
                        n_state = BK_OUT;
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = BK_COEF;
                    end
                end else begin
                    n_step  = r_step + 2'd1;
                    n_state = BK_MUL;
                end
            end
            BK_CLAMP: begin
                // r_first carries the low-side flag here
                if (r_op == OP_POS) begin
                    n_res = '{i_row_rdata.px, i_row_rdata.py, i_row_rdata.pz};
                end else if (r_first[0]) begin
                    n_res = '{i_row_rdata.inx, i_row_rdata.iny, i_row_rdata.inz};
                end else begin
                    n_res = '{i_row_rdata.outx, i_row_rdata.outy, i_row_rdata.outz};
                end
                n_state = BK_OUT;
            end
            BK_OUT: n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op <= n_op; r_t <= n_t; r_first <= n_first; r_last <= n_last;
        r_t0 <= n_t0; r_t1 <= n_t1; r_idx <= n_idx; r_rem <= n_rem; r_den <= n_den;
        r_u <= n_u; r_div_cnt <= n_div_cnt; r_row0 <= n_row0; r_row1 <= n_row1;
        r_comp <= n_comp; r_step <= n_step; r_b <= n_b; r_h <= n_h; r_prod <= n_prod;
        r_res <= n_res; r_few <= n_few;
    end

    assign o_result_strobe = (r_state == BK_OUT);
    assign o_result_x      = r_res[0];
    assign o_result_y      = r_res[1];
    assign o_result_z      = r_res[2];
    assign o_too_few_keys  = r_few;

    `HSE_ASSERT(a_pop_idle, o_pop |-> (r_state == BK_IDLE && i_head.valid))
    `HSE_ASSERT(a_div_cnt, (r_state == BK_DIV) |-> (r_div_cnt != '0))
    `HSE_ASSERT(a_search_bound, (r_state == BK_SEARCH) |-> ((c_nidx + ONE_C) < i_key_num))
    `HSE_ASSERT(a_u_range, (r_state == BK_ROW0) |-> (r_u <= (UW'(1) << FRAC_BITS)))
    `HSE_ASSERT(a_strobe_pulse, o_result_strobe |=> !o_result_strobe)
endmodule

[rtl/core/hermite_spline_evaluator_core.sv]
// top level of the cubic hermite spline evaluator
`timescale 1ns / 1ps
// usage
// - a transaction enters when start is high and busy is low; opcode load writes one
//   key slot (time, position, segment in and out tangents), the other opcodes ask for
//   position, velocity or acceleration at i_time_value (signed q16.16)
// - i_cfg_we writes key_count; write it only with no transaction outstanding
// - each query gives one result, shown for exactly one cycle with o_result_strobe high;
//   the receiver cannot hold results off, loads give none
// - a two-entry queue sits between the accepting front end and the evaluating back end,
//   busy rises only when it is full
// - a load is written to the key memories as the back end pops it; a query is popped,
//   reads the first and last key times, searches the segment key by key (passing at most
//   key count - 2 keys), sets up and runs the restoring divider for u, reads the key rows,
//   then does a coefficient step and the horner steps per axis (3, 2 or 1 steps), then
//   shows the result; the sequencer in the back end and the single read port of each key
//   memory set this pace
// - fewer than two keys gives a zero result with o_too_few_keys set
// - reset is synchronous, active low; it clears key_count and the control state,
//   the key memories keep whatever they hold and need loading before use
module hermite_spline_evaluator_core import hse_pkg::*; #(
    parameter int MAX_KEYS  = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic [1:0]              i_opcode,
    input  logic [IDX_W-1:0]        i_key_index,
    input  logic signed [VAL_W-1:0] i_time_value,
    input  logic signed [VAL_W-1:0] i_pos_x,
    input  logic signed [VAL_W-1:0] i_pos_y,
    input  logic signed [VAL_W-1:0] i_pos_z,
    input  logic signed [VAL_W-1:0] i_in_tan_x,
    input  logic signed [VAL_W-1:0] i_in_tan_y,
    input  logic signed [VAL_W-1:0] i_in_tan_z,
    input  logic signed [VAL_W-1:0] i_out_tan_x,
    input  logic signed [VAL_W-1:0] i_out_tan_y,
    input  logic signed [VAL_W-1:0] i_out_tan_z,
    output logic                    o_result_strobe,
    output logic signed [VAL_W-1:0] o_result_x,
    output logic signed [VAL_W-1:0] o_result_y,
    output logic signed [VAL_W-1:0] o_result_z,
    output logic                    o_too_few_keys
);
    localparam int AW = $clog2(MAX_KEYS);
    // count width: holds both the 7-bit register and the table depth
    localparam int CW = ($clog2(MAX_KEYS + 1) > CNT_W) ? $clog2(MAX_KEYS + 1) : CNT_W;

    t_row                    in_row;
    t_q_head                 head;
    logic [CW-1:0]           key_num;
    logic                    q_pop;
    logic                    key_we;
    logic [AW-1:0]           key_waddr;
    logic [AW-1:0]           tm_raddr;
    logic [AW-1:0]           row_raddr;
    logic signed [VAL_W-1:0] tm_rdata;
    t_row                    row_rdata;

    assign in_row = '{i_pos_x, i_pos_y, i_pos_z, i_in_tan_x, i_in_tan_y, i_in_tan_z,
                      i_out_tan_x, i_out_tan_y, i_out_tan_z};

    // front end: classification and queue
    hse_front #(.MAX_KEYS(MAX_KEYS), .CW(CW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .o_busy       (busy),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_opcode     (i_opcode),
        .i_key_index  (i_key_index),
        .i_time_value (i_time_value),
        .i_row        (in_row),
        .i_pop        (q_pop),
        .o_head       (head),
        .o_key_num    (key_num)
    );

    // key times live apart so the search reads them alone
    hse_ram #(.WIDTH(VAL_W), .DEPTH(MAX_KEYS)) u_time_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (head.item.tval),
        .i_raddr (tm_raddr),
        .o_rdata (tm_rdata)
    );

    // positions and tangents, one row per key
    hse_ram #(.WIDTH($bits(t_row)), .DEPTH(MAX_KEYS)) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (head.item.row),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata)
    );

    // back end: search, divide, evaluate
    hse_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS), .CW(CW)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_key_num       (key_num),
        .o_pop           (q_pop),
        .o_we            (key_we),
        .o_waddr         (key_waddr),
        .o_tm_raddr      (tm_raddr),
        .i_tm_rdata      (tm_rdata),
        .o_row_raddr     (row_raddr),
        .i_row_rdata     (row_rdata),
        .o_result_strobe (o_result_strobe),
        .o_result_x      (o_result_x),
        .o_result_y      (o_result_y),
        .o_result_z      (o_result_z),
        .o_too_few_keys  (o_too_few_keys)
    );
endmodule

[tb/tb_hermite_spline_evaluator_core.sv]
// self-checking testbench for the cubic hermite spline evaluator core
`timescale 1ns / 1ps
module tb_hermite_spline_evaluator_core;
    import hse_pkg::*;

    typedef logic signed [VAL_W-1:0] q16_t;

    // one evaluated vector as the core should present it
    typedef struct {
        q16_t x;
        q16_t y;
        q16_t z;
        bit   few;
    } spline_vec_t;

    localparam int QUIET_LIMIT = 4000;   // cycles with neither an accepted transaction nor a result
    localparam int SETTLE      = 150;    // covers the longest query plus the queue
    localparam int TARGET      = 850;

    // shadow of the key table and the key count, plus the results still owed by the core
    class spline_scoreboard;
        q16_t        key_t[64];
        t_row        rows[64];
        int unsigned keys_used;
        spline_vec_t due[$];
        int unsigned mismatches;
        int unsigned checked;

        function void set_key_count(logic [CNT_W-1:0] v);
            keys_used = v;
        endfunction

        function int pending();
            return due.size();
        endfunction

        // a*u with the product shifted down, rounding toward minus infinity
        function longint scale_u(longint a, longint u);
            return (a * u) >>> 16;
        endfunction

        function q16_t clip(longint v);
            if (v > 64'sd2147483647) return 32'sh7fff_ffff;
            if (v < -64'sd2147483648) return 32'sh8000_0000;
            return q16_t'(v);
        endfunction

        function longint seg_u(longint t, longint t0, longint t1);
            longint num;
            longint den;
            num = t - t0;
            den = t1 - t0;
            if (num <= 0 || den <= 0) return 0;
            if (num >= den) return 64'sd65536;
            return (num <<< 16) / den;
        endfunction

        function void axis(t_row r, int ax, output longint p, output longint ti,
                           output longint to);
            case (ax)
                0: begin p = r.px; ti = r.inx; to = r.outx; end
                1: begin p = r.py; ti = r.iny; to = r.outy; end
                default: begin p = r.pz; ti = r.inz; to = r.outz; end
            endcase
        endfunction

        function void note_input(t_opcode op, logic [IDX_W-1:0] idx, q16_t tval, t_row row);
            int unsigned n;
            int unsigned i;
            longint t, first, last, u;
            longint p0, p1, t0, t1, a, b, d0, d1, v;
            longint res[3];
            spline_vec_t e;
            if (op == OP_LOAD) begin
                key_t[idx] = tval;
                rows[idx]  = row;
                return;
            end
            n = (keys_used > 64) ? 64 : keys_used;
            e.few = 0;
            if (n < 2) begin
                e = '{0, 0, 0, 1};
                due.push_back(e);
                return;
            end
            t     = tval;
            first = key_t[0];
            last  = key_t[n-1];
            i     = 0;
            if (op != OP_ACC) begin
                if (t <= first || t >= last) begin
                    for (int ax = 0; ax < 3; ax++) begin
                        if (op == OP_POS) begin
                            axis(rows[(t <= first) ? 0 : n-1], ax, p0, t0, t1);
                            res[ax] = p0;
                        end else if (t <= first) begin
                            axis(rows[0], ax, p0, t0, t1);
                            res[ax] = t0;
                        end else begin
                            axis(rows[n-2], ax, p0, t0, t1);
                            res[ax] = t1;
                        end
                    end
                    e.x = clip(res[0]); e.y = clip(res[1]); e.z = clip(res[2]);
                    due.push_back(e);
                    return;
                end
                while (i < n-2 && !(t < longint'(key_t[i+1]))) i++;
            end else begin
                if (t <= first) t = first;
                else if (t > last) t = last;
                while (i < n-2 && !(t <= longint'(key_t[i+1]))) i++;
            end
            u = seg_u(t, key_t[i], key_t[i+1]);
            for (int ax = 0; ax < 3; ax++) begin
                axis(rows[i], ax, p0, t0, t1);
                axis(rows[i+1], ax, p1, d0, d1);
                a = 2*p0 - 2*p1 + t0 + t1;
                b = -3*p0 + 3*p1 - 2*t0 - t1;
                case (op)
                    OP_POS:  v = p0 + scale_u(t0 + scale_u(b + scale_u(a, u), u), u);
                    OP_VEL:  v = t0 + scale_u(2*b + scale_u(3*a, u), u);
                    default: v = 2*b + scale_u(6*a, u);
                endcase
                res[ax] = v;
            end
            e.x = clip(res[0]); e.y = clip(res[1]); e.z = clip(res[2]);
            due.push_back(e);
        endfunction

        function void check_result(q16_t x, q16_t y, q16_t z, bit few);
            spline_vec_t e;
            checked++;
            if (due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing outstanding: x=%0d y=%0d z=%0d few=%0b",
                             x, y, z, few);
                return;
            end
            e = due.pop_front();
            if (e.x !== x || e.y !== y || e.z !== z || e.few !== few) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp x=%0d y=%0d z=%0d few=%0b, got x=%0d y=%0d z=%0d few=%0b",
                             e.x, e.y, e.z, e.few, x, y, z, few);
            end
        endfunction
    endclass

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               start = 0;
    logic               busy;
    logic               i_cfg_we = 0;
    logic [CNT_W-1:0]   i_cfg_wdata = '0;
    logic [1:0]         i_opcode = '0;
    logic [IDX_W-1:0]   i_key_index = '0;
    q16_t               i_time_value = '0;
    q16_t               i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    q16_t               i_in_tan_x = '0, i_in_tan_y = '0, i_in_tan_z = '0;
    q16_t               i_out_tan_x = '0, i_out_tan_y = '0, i_out_tan_z = '0;
    logic               o_result_strobe;
    q16_t               o_result_x, o_result_y, o_result_z;
    logic               o_too_few_keys;

    spline_scoreboard sb = new();

    q16_t        key_times[64];  // driver's own copy of the loaded times, to aim queries
    int unsigned sent, loads, queries, phases;
    int unsigned idle_pct;
    int unsigned quiet;

    hermite_spline_evaluator_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_key_index    (i_key_index),
        .i_time_value   (i_time_value),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_in_tan_x     (i_in_tan_x),
        .i_in_tan_y     (i_in_tan_y),
        .i_in_tan_z     (i_in_tan_z),
        .i_out_tan_x    (i_out_tan_x),
        .i_out_tan_y    (i_out_tan_y),
        .i_out_tan_z    (i_out_tan_z),
        .o_result_strobe(o_result_strobe),
        .o_result_x     (o_result_x),
        .o_result_y     (o_result_y),
        .o_result_z     (o_result_z),
        .o_too_few_keys (o_too_few_keys)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // results cannot be held off, so every strobe is a transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            sb.check_result(o_result_x, o_result_y, o_result_z, o_too_few_keys);
    end

    // watchdog: a stuck core shows up as a long stretch with no traffic either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_result_strobe) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", sb.pending());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // mix of plain random, small, saturating extremes and near-zero values
    function automatic q16_t rnd_val();
        case ($urandom_range(0, 6))
            0, 1:    return q16_t'($urandom);
            2:       return q16_t'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            3:       return 32'sh7fff_ffff;
            4:       return 32'sh8000_0000;
            5:       return q16_t'(int'($urandom_range(0, 4)) - 2);
            default: return q16_t'(int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
        endcase
    endfunction

    function automatic t_row rnd_row();
        t_row r;
        r.px = rnd_val(); r.py = rnd_val(); r.pz = rnd_val();
        r.inx = rnd_val(); r.iny = rnd_val(); r.inz = rnd_val();
        r.outx = rnd_val(); r.outy = rnd_val(); r.outz = rnd_val();
        return r;
    endfunction

    // one transaction; start stays high afterwards so back-to-back items need no re-raise
    task automatic send(t_opcode op, logic [IDX_W-1:0] idx, q16_t tv, t_row row);
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_key_index  <= idx;
        i_time_value <= tv;
        i_pos_x      <= row.px;   i_pos_y    <= row.py;   i_pos_z    <= row.pz;
        i_in_tan_x   <= row.inx;  i_in_tan_y <= row.iny;  i_in_tan_z <= row.inz;
        i_out_tan_x  <= row.outx; i_out_tan_y <= row.outy; i_out_tan_z <= row.outz;
        do @(posedge i_clk); while (busy);
        sb.note_input(op, idx, tv, row);
        if (op == OP_LOAD) begin
            key_times[idx] = tv;
            loads++;
        end else begin
            queries++;
        end
        sent++;
    endtask

    // hold off until every owed result is in, then let any trailing load finish
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CNT_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_key_count(v);
    endtask

    // query times mostly inside the key span, also on and next to key times and far outside
    function automatic q16_t query_time(int unsigned nk);
        longint f, l, r;
        if (nk < 2) return rnd_val();
        f = key_times[0];
        l = key_times[nk-1];
        r = longint'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                if (l > f) return q16_t'(f + (r % (l - f + 1)));
                return rnd_val();
            end
            5, 6:    return key_times[$urandom_range(0, nk-1)] + q16_t'(int'($urandom_range(0, 2)) - 1);
            7:       return rnd_val();
            8:       return $urandom_range(0, 1) ? key_times[0] - 1 : key_times[nk-1] + 1;
            default: return $urandom_range(0, 1) ? 32'sh8000_0000 : 32'sh7fff_ffff;
        endcase
    endfunction

    // fill the key slots in use, program the count, then a run of queries with stray loads
    task automatic run_phase(int unsigned count, int unsigned n_queries);
        int unsigned nk;
        int unsigned style;
        longint      cur;
        longint      span;
        q16_t        tv;
        t_opcode     op;
        nk    = (count > 64) ? 64 : count;
        style = $urandom_range(0, 4);
        cur   = (style == 2) ? -64'sd2147483648 + $urandom_range(0, 1000)
                             : longint'($urandom_range(0, 32'h0020_0000)) - 64'sd1048576;
        span  = (nk > 1) ? (64'sd4294965000 / nk) : 1;
        if (nk >= 2) begin
            for (int k = 0; k < nk; k++) begin
                case (style)
                    0: tv = rnd_val();                           // unsorted key times
                    1: begin                                     // sorted, with repeated times
                        tv = q16_t'(cur);
                        if ($urandom_range(0, 2) != 0) cur += $urandom_range(1, 32'h0004_0000);
                    end
                    2: begin                                     // spread over the whole range
                        tv = q16_t'(cur);
                        cur += $urandom_range(1, span);
                    end
                    default: begin
                        tv = q16_t'(cur);
                        cur += $urandom_range(1, 32'h0004_0000);
                    end
                endcase
                send(OP_LOAD, k[IDX_W-1:0], tv, rnd_row());
            end
        end
        write_count(count[CNT_W-1:0]);
        for (int q = 0; q < n_queries; q++) begin
            if (phases == 3 && q == n_queries / 2) drain();
            if ($urandom_range(0, 9) == 0) begin
                send(OP_LOAD, IDX_W'($urandom_range(0, 63)), query_time(nk), rnd_row());
            end else begin
                op = t_opcode'($urandom_range(1, 3));
                send(op, IDX_W'($urandom), query_time(nk), rnd_row());
            end
        end
        phases++;
    endtask

    initial begin
        t_row hi_row;
        t_row lo_row;
        t_row mix_row;
        int unsigned count;
        idle_pct = 32;
        hi_row   = {9{32'sh7fff_ffff}};
        lo_row   = {9{32'sh8000_0000}};
        mix_row  = {32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, 32'sh8000_0000, 32'sh7fff_ffff,
                    32'sh1, 32'sh7fff_ffff, 32'sh8000_0000, -32'sh1};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: no keys in use, every query kind gives zero with the flag
        send(OP_POS, '0, 32'sh8000_0000, hi_row);
        send(OP_VEL, '1, 32'sh7fff_ffff, lo_row);
        send(OP_ACC, '0, 32'sh0, mix_row);

        // directed: four keys with extreme content, a repeated time and extreme times
        send(OP_LOAD, 6'd0, 32'sh8000_0000, hi_row);
        send(OP_LOAD, 6'd1, 32'sh0000_0000, lo_row);
        send(OP_LOAD, 6'd2, 32'sh0000_0000, mix_row);
        send(OP_LOAD, 6'd3, 32'sh7fff_ffff, hi_row);
        for (int k = 0; k < 4; k++) key_times[k] = (k == 0) ? 32'sh8000_0000 :
                                                   (k == 3) ? 32'sh7fff_ffff : 32'sh0;
        write_count(7'd1);
        send(OP_POS, '0, 32'sh0, hi_row);
        write_count(7'd4);
        // clamps at both ends, on the repeated key time and just either side of it
        send(OP_POS, '0, 32'sh8000_0000, lo_row);
        send(OP_VEL, '0, 32'sh8000_0000, lo_row);
        send(OP_ACC, '0, 32'sh8000_0000, lo_row);
        send(OP_POS, '0, 32'sh7fff_ffff, lo_row);
        send(OP_VEL, '0, 32'sh7fff_ffff, lo_row);
        send(OP_ACC, '0, 32'sh7fff_ffff, lo_row);
        send(OP_POS, '0, 32'sh0, lo_row);
        send(OP_VEL, '0, -32'sh1, lo_row);
        send(OP_ACC, '0, 32'sh0, lo_row);
        send(OP_POS, '0, 32'sh1, lo_row);
        send(OP_ACC, '0, 32'sh4000_0000, lo_row);

        // random phases: first the extremes of the key count, then mostly small tables
        while (sent < TARGET) begin
            if (sent >= 600)      idle_pct = 0;
            else if (sent >= 300) idle_pct = 81;
            case (phases)
                0: count = 2;
                1: count = 64;
                2: count = 127;
                3: count = 0;
                4: count = 1;
                5: count = 3;
                default: begin
                    case ($urandom_range(0, 9))
                        0:       count = $urandom_range(0, 1);
                        1:       count = $urandom_range(9, 64);
                        2:       count = $urandom_range(65, 127);
                        default: count = $urandom_range(2, 8);
                    endcase
                end
            endcase
            run_phase(count, $urandom_range(30, 50));
        end

        drain();
        $display("%0d transactions sent (%0d loads, %0d queries) over %0d key table settings",
                 sent, loads, queries, phases);
        $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
